// ===== hdl/khm_pkg.sv =====
// Shared type (op_t) and constant (WAY_W) for the k-way heap merge core.
// No dependencies; used by khm_cell and kway_heap_merge_core.

package khm_pkg;

  // Way (run number) tag width, fixed by the stream format
  localparam int WAY_W = 7;

  // Per-cycle command broadcast to every cell of the sorted row
  typedef enum logic [1:0] {
    OP_HOLD    = 2'd0,  // keep contents
    OP_INSERT  = 2'd1,  // open a slot and insert the new entry
    OP_REPLACE = 2'd2,  // drop the head and insert the new entry
    OP_SHIFT   = 2'd3   // drop the head, everything moves toward the head
  } op_t;

endpackage

// ===== hdl/kway_heap_merge_core.sv =====
// K-way merge core: priority queue of run heads kept as a sorted row of cells.
// A pop beat's result is registered and appears on out_* in the cycle after the beat is accepted.
// Throughput: one beat per cycle unless the output stalls; the whole row re-sorts in the accept cycle.
// Input stalls only while a result is held and out_tready is low.
// Reset (rst_n low, synchronous) empties the queue and the output register;
// cell contents are left as they are.
// Depends on khm_pkg and khm_cell.

module kway_heap_merge_core #(
  parameter int WAYS     = 128,
  parameter int KEY_BITS = 32,
  localparam int DATA_W  = ((KEY_BITS + khm_pkg::WAY_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // in_key, in_way, zero pad
  input  logic [1:0]        in_tuser,   // req_type, has_refill
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // out_key, out_way, zero pad
  output logic              out_tlast,  // now_empty
  output logic              out_tuser   // underflow
);

  localparam int CNT_W = $clog2(WAYS + 1);
  localparam int WW    = khm_pkg::WAY_W;

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [KEY_BITS-1:0] out_key_r, out_key_nxt;
  logic [WW-1:0]       out_way_r, out_way_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_uf_r, out_uf_nxt;

  khm_pkg::op_t        op;
  logic                in_beat;
  logic                req_pop;
  logic                has_refill;
  logic [KEY_BITS-1:0] new_key;
  logic [WW-1:0]       new_way;

  logic [KEY_BITS-1:0] key_w [WAYS];
  logic [WW-1:0]       way_w [WAYS];
  logic                lt_w  [WAYS];

  assign new_key    = in_tdata[KEY_BITS-1:0];
  assign new_way    = in_tdata[KEY_BITS +: WW];
  assign req_pop    = in_tuser[0];
  assign has_refill = in_tuser[1];

  // Accept while the output register is free or draining
  assign in_tready = !out_valid_r || out_tready;
  assign in_beat   = in_tvalid && in_tready;

  // Row of cells, head (smallest entry) at index 0
  for (genvar i = 0; i < WAYS; i++) begin : g_cell
    logic [KEY_BITS-1:0] prev_key, next_key;
    logic [WW-1:0]       prev_way, next_way;
    logic                prev_lt, next_lt;

    if (i == 0) begin : g_head
      assign prev_key = '0;
      assign prev_way = '0;
      assign prev_lt  = 1'b0;
    end else begin : g_mid
      assign prev_key = key_w[i-1];
      assign prev_way = way_w[i-1];
      assign prev_lt  = lt_w[i-1];
    end

    if (i == WAYS - 1) begin : g_tail
      assign next_key = '0;
      assign next_way = '0;
      assign next_lt  = 1'b1;
    end else begin : g_body
      assign next_key = key_w[i+1];
      assign next_way = way_w[i+1];
      assign next_lt  = lt_w[i+1];
    end

    khm_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk        (clk),
      .op_i       (op),
      .valid_i    (CNT_W'(i) < count_r),
      .new_key_i  (new_key),
      .new_way_i  (new_way),
      .prev_key_i (prev_key),
      .prev_way_i (prev_way),
      .prev_lt_i  (prev_lt),
      .next_key_i (next_key),
      .next_way_i (next_way),
      .next_lt_i  (next_lt),
      .key_o      (key_w[i]),
      .way_o      (way_w[i]),
      .lt_o       (lt_w[i])
    );
  end

  // Request decode, fill count and result register
  always_comb begin
    op            = khm_pkg::OP_HOLD;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_key_nxt   = out_key_r;
    out_way_nxt   = out_way_r;
    out_last_nxt  = out_last_r;
    out_uf_nxt    = out_uf_r;
    if (in_beat) begin
      if (!req_pop) begin
        // load: ignored when full
        if (count_r != CNT_W'(WAYS)) begin
          op        = khm_pkg::OP_INSERT;
          count_nxt = count_r + 1'b1;
        end
      end else begin
        out_valid_nxt = 1'b1;
        out_uf_nxt    = 1'b0;
        if (has_refill) begin
          // refill ahead of the head (or empty row) passes straight through
          out_last_nxt = count_r == '0;
          if (lt_w[0]) begin
            out_key_nxt = new_key;
            out_way_nxt = new_way;
          end else begin
            op          = khm_pkg::OP_REPLACE;
            out_key_nxt = key_w[0];
            out_way_nxt = way_w[0];
          end
        end else if (count_r == '0) begin
          out_key_nxt  = '0;
          out_way_nxt  = '0;
          out_last_nxt = 1'b1;
          out_uf_nxt   = 1'b1;
        end else begin
          op           = khm_pkg::OP_SHIFT;
          count_nxt    = count_r - 1'b1;
          out_key_nxt  = key_w[0];
          out_way_nxt  = way_w[0];
          out_last_nxt = count_r == CNT_W'(1);
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_key_r  <= out_key_nxt;
    out_way_r  <= out_way_nxt;
    out_last_r <= out_last_nxt;
    out_uf_r   <= out_uf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'({out_way_r, out_key_r});
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_uf_r;

endmodule

// ===== hdl/khm_cell.sv =====
// One cell of the sorted entry row: holds a single key/way pair.
// Depends on khm_pkg (op_t, WAY_W).

module khm_cell #(
  parameter int KEY_BITS = 32
) (
  input  logic                       clk,
  input  khm_pkg::op_t               op_i,
  input  logic                       valid_i,     // cell lies below the fill count
  input  logic [KEY_BITS-1:0]        new_key_i,
  input  logic [khm_pkg::WAY_W-1:0]  new_way_i,
  // neighbor toward the head
  input  logic [KEY_BITS-1:0]        prev_key_i,
  input  logic [khm_pkg::WAY_W-1:0]  prev_way_i,
  input  logic                       prev_lt_i,
  // neighbor toward the tail
  input  logic [KEY_BITS-1:0]        next_key_i,
  input  logic [khm_pkg::WAY_W-1:0]  next_way_i,
  input  logic                       next_lt_i,
  // own contents and compare result
  output logic [KEY_BITS-1:0]        key_o,
  output logic [khm_pkg::WAY_W-1:0]  way_o,
  output logic                       lt_o         // new entry orders before this cell
);

  logic [KEY_BITS-1:0]       key_r, key_nxt;
  logic [khm_pkg::WAY_W-1:0] way_r, way_nxt;
  logic                      key_less;
  logic                      key_same;

  // Order: signed key, then smaller way; an empty cell counts as +infinity
  assign key_less = $signed(new_key_i) < $signed(key_r);
  assign key_same = new_key_i == key_r;
  assign lt_o     = !valid_i || key_less || (key_same && (new_way_i < way_r));

  // Next contents from the broadcast command and the neighbors
  always_comb begin
    key_nxt = key_r;
    way_nxt = way_r;
    case (op_i)
      khm_pkg::OP_INSERT: begin
        if (lt_o) begin
          if (prev_lt_i) begin
            key_nxt = prev_key_i;
            way_nxt = prev_way_i;
          end else begin
            key_nxt = new_key_i;
            way_nxt = new_way_i;
          end
        end
      end
      khm_pkg::OP_REPLACE: begin
        if (!next_lt_i) begin
          key_nxt = next_key_i;
          way_nxt = next_way_i;
        end else if (!lt_o) begin
          key_nxt = new_key_i;
          way_nxt = new_way_i;
        end
      end
      khm_pkg::OP_SHIFT: begin
        key_nxt = next_key_i;
        way_nxt = next_way_i;
      end
      default: begin
        key_nxt = key_r;
        way_nxt = way_r;
      end
    endcase
  end

  // Payload only, no reset
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    way_r <= way_nxt;
  end

  assign key_o = key_r;
  assign way_o = way_r;

endmodule
